/* src/msie_pkg.sv */
// ============================================================================
// msie_pkg
// Shared types and constants for the MIPS subset instruction executor.
// ============================================================================
package msie_pkg;

    localparam logic [31:0] STACK_TOP_RESET = 32'd1048572;

    typedef enum logic [2:0] {
        PK_NONE = 3'd0,
        PK_LB   = 3'd1,
        PK_LBU  = 3'd2,
        PK_LH   = 3'd3,
        PK_LHU  = 3'd4,
        PK_LW   = 3'd5
    } pend_kind_t;

    typedef enum logic [1:0] {
        MEM_NONE  = 2'd0,
        MEM_LOAD  = 2'd1,
        MEM_STORE = 2'd2
    } mem_op_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_EXEC  = 3'd1,
        ST_MUL   = 3'd2,
        ST_DIV   = 3'd3,
        ST_DFIX  = 3'd4,
        ST_OUT   = 3'd5
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load_in;    // capture input item, read operands
        logic exec;       // execute item, build result
        logic mul_start;
        logic mul_step;   // second partial-product pass
        logic div_start;
        logic div_step;
        logic div_fix;    // apply signs, write HI/LO
        logic out_clear;  // result taken
    } ctrl_t;

    // datapath -> controller
    typedef struct packed {
        logic is_mul;
        logic is_div;
        logic div_done;
    } stat_t;

    localparam logic [5:0] OP_SPECIAL = 6'd0;
    localparam logic [5:0] OP_J     = 6'd2;
    localparam logic [5:0] OP_JAL   = 6'd3;
    localparam logic [5:0] OP_BEQ   = 6'd4;
    localparam logic [5:0] OP_BNE   = 6'd5;
    localparam logic [5:0] OP_BLEZ  = 6'd6;
    localparam logic [5:0] OP_BGTZ  = 6'd7;
    localparam logic [5:0] OP_ADDI  = 6'd8;
    localparam logic [5:0] OP_ADDIU = 6'd9;
    localparam logic [5:0] OP_SLTI  = 6'd10;
    localparam logic [5:0] OP_SLTIU = 6'd11;
    localparam logic [5:0] OP_ANDI  = 6'd12;
    localparam logic [5:0] OP_ORI   = 6'd13;
    localparam logic [5:0] OP_XORI  = 6'd14;
    localparam logic [5:0] OP_LB    = 6'd32;
    localparam logic [5:0] OP_LH    = 6'd33;
    localparam logic [5:0] OP_LW    = 6'd35;
    localparam logic [5:0] OP_LBU   = 6'd36;
    localparam logic [5:0] OP_LHU   = 6'd37;
    localparam logic [5:0] OP_SB    = 6'd40;
    localparam logic [5:0] OP_SH    = 6'd41;
    localparam logic [5:0] OP_SW    = 6'd43;

    localparam logic [5:0] FN_SLL   = 6'd0;
    localparam logic [5:0] FN_SRL   = 6'd2;
    localparam logic [5:0] FN_SRA   = 6'd3;
    localparam logic [5:0] FN_SLLV  = 6'd4;
    localparam logic [5:0] FN_SRLV  = 6'd6;
    localparam logic [5:0] FN_JR    = 6'd8;
    localparam logic [5:0] FN_JALR  = 6'd9;
    localparam logic [5:0] FN_SYSC  = 6'd12;
    localparam logic [5:0] FN_MFHI  = 6'd16;
    localparam logic [5:0] FN_MTHI  = 6'd17;
    localparam logic [5:0] FN_MFLO  = 6'd18;
    localparam logic [5:0] FN_MTLO  = 6'd19;
    localparam logic [5:0] FN_MULT  = 6'd24;
    localparam logic [5:0] FN_MULTU = 6'd25;
    localparam logic [5:0] FN_DIV   = 6'd26;
    localparam logic [5:0] FN_DIVU  = 6'd27;
    localparam logic [5:0] FN_ADD   = 6'd32;
    localparam logic [5:0] FN_ADDU  = 6'd33;
    localparam logic [5:0] FN_SUB   = 6'd34;
    localparam logic [5:0] FN_SUBU  = 6'd35;
    localparam logic [5:0] FN_AND   = 6'd36;
    localparam logic [5:0] FN_OR    = 6'd37;
    localparam logic [5:0] FN_XOR   = 6'd38;
    localparam logic [5:0] FN_NOR   = 6'd39;
    localparam logic [5:0] FN_SLT   = 6'd42;
    localparam logic [5:0] FN_SLTU  = 6'd43;

endpackage

/* src/msie_ctrl.sv */
// ============================================================================
// msie_ctrl
// Sequencer for one item at a time: capture, execute, multiply, divide, output.
// ============================================================================
module msie_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_fire,
    input  logic             out_fire,
    input  msie_pkg::stat_t  stat,
    output msie_pkg::ctrl_t  ctrl,
    output logic             in_ready,
    output logic             out_valid
);

    msie_pkg::state_t state_reg;
    msie_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= msie_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            msie_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = msie_pkg::ST_EXEC;
                end
            end
            msie_pkg::ST_EXEC:
            begin
                if (stat.is_mul)
                begin
                    state_next = msie_pkg::ST_MUL;
                end
                else if (stat.is_div)
                begin
                    state_next = msie_pkg::ST_DIV;
                end
                else
                begin
                    state_next = msie_pkg::ST_OUT;
                end
            end
            msie_pkg::ST_MUL:
            begin
                state_next = msie_pkg::ST_OUT;
            end
            msie_pkg::ST_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = msie_pkg::ST_DFIX;
                end
            end
            msie_pkg::ST_DFIX:
            begin
                state_next = msie_pkg::ST_OUT;
            end
            msie_pkg::ST_OUT:
            begin
                if (out_fire)
                begin
                    state_next = msie_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = msie_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl      = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            msie_pkg::ST_IDLE:
            begin
                in_ready      = 1'b1;
                ctrl.load_in  = in_fire;
            end
            msie_pkg::ST_EXEC:
            begin
                ctrl.exec      = 1'b1;
                ctrl.mul_start = stat.is_mul;
                ctrl.div_start = stat.is_div;
            end
            msie_pkg::ST_MUL:
            begin
                ctrl.mul_step = 1'b1;
            end
            msie_pkg::ST_DIV:
            begin
                ctrl.div_step = 1'b1;
            end
            msie_pkg::ST_DFIX:
            begin
                ctrl.div_fix = 1'b1;
            end
            msie_pkg::ST_OUT:
            begin
                out_valid      = 1'b1;
                ctrl.out_clear = out_fire;
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctrl.exec, ctrl.mul_step, ctrl.div_step, ctrl.div_fix}))
        else $error("multiple datapath commands");
    a_div_fix: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.div_fix |-> $past(ctrl.div_step))
        else $error("divide fixup without divide");
    a_out_after: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire |=> in_ready)
        else $error("not ready after result");
`endif

endmodule

/* src/msie_dp.sv */
// ============================================================================
// msie_dp
// Datapath: register file, PC, HI/LO, pending load, multiplier, divider.
// ============================================================================
module msie_dp #(
    parameter int REG_COUNT = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  msie_pkg::ctrl_t  ctrl,
    output msie_pkg::stat_t  stat,
    input  logic             cfg_fire,
    input  logic [31:0]      cfg_data,
    input  logic             kind,
    input  logic [31:0]      instr_word,
    input  logic [31:0]      load_data,
    output logic [31:0]      next_pc,
    output logic [1:0]       mem_op,
    output logic [31:0]      mem_addr,
    output logic [1:0]       mem_size,
    output logic [31:0]      store_value,
    output logic             syscall_flag,
    output logic [31:0]      syscall_code
);

    localparam int RW = $clog2(REG_COUNT);

    logic [31:0] gpr_reg [REG_COUNT];
    logic [31:0] pc_reg, hi_reg, lo_reg;
    logic [RW-1:0] pdest_reg;
    msie_pkg::pend_kind_t pkind_reg;

    logic        kind_reg;
    logic [31:0] w_reg, ld_reg, a_reg, b_reg, v0_reg;

    // result registers
    logic [31:0] npc_reg, addr_reg, sval_reg, scode_reg;
    logic [1:0]  mop_reg, msize_reg;
    logic        sflag_reg;

    // multiply: two 33x17 partial products, summed in the second pass
    logic [63:0] prod_reg;    // a * b[15:0], sign-extended
    logic [47:0] ma_reg;      // a * b[32:16], low bits that reach the product

    // divide: restoring, one bit per cycle on magnitudes
    logic [31:0] dq_reg, dr_reg, dd_reg, dnum_reg;
    logic [5:0]  dcnt_reg;
    logic        dneg_q_reg, dneg_r_reg, dzero_reg;

    logic [5:0] opc, fn;
    logic [4:0] rs, rt, rd, sh;
    logic [31:0] simm, imm, br, ea, pc4;
    assign opc  = w_reg[31:26];
    assign rs   = w_reg[25:21];
    assign rt   = w_reg[20:16];
    assign rd   = w_reg[15:11];
    assign sh   = w_reg[10:6];
    assign fn   = w_reg[5:0];
    assign imm  = {16'd0, w_reg[15:0]};
    assign simm = {{16{w_reg[15]}}, w_reg[15:0]};
    assign br   = pc_reg + {simm[29:0], 2'b00};
    assign ea   = a_reg + simm;
    assign pc4  = pc_reg + 32'd4;

    assign stat.is_mul = !kind_reg && opc == msie_pkg::OP_SPECIAL
                         && (fn == msie_pkg::FN_MULT || fn == msie_pkg::FN_MULTU);
    assign stat.is_div = !kind_reg && opc == msie_pkg::OP_SPECIAL
                         && (fn == msie_pkg::FN_DIV || fn == msie_pkg::FN_DIVU);
    assign stat.div_done = dcnt_reg == 6'd0;

    // execute step: register write, next PC, request
    logic          wen;
    logic [RW-1:0] wdst;
    logic [31:0]   wval, npc;
    logic [1:0]    mop, msize;
    logic [31:0]   maddr, sval;
    logic          sflag, hi_wen, lo_wen;
    logic          new_load;
    msie_pkg::pend_kind_t nkind;
    logic [31:0]   sra_v;

    assign sra_v = $unsigned($signed(b_reg) >>> sh);

    always_comb
    begin
        wen = 1'b0; wdst = rd[RW-1:0]; wval = '0; npc = pc4;
        mop = msie_pkg::MEM_NONE; msize = 2'd0; maddr = '0; sval = '0;
        sflag = 1'b0; hi_wen = 1'b0; lo_wen = 1'b0;
        new_load = 1'b0; nkind = msie_pkg::PK_NONE;
        if (kind_reg)
        begin
            npc  = pc_reg;
            wdst = pdest_reg;
            wen  = pkind_reg != msie_pkg::PK_NONE;
            case (pkind_reg)
                msie_pkg::PK_LB:  wval = {{24{ld_reg[7]}}, ld_reg[7:0]};
                msie_pkg::PK_LBU: wval = {24'd0, ld_reg[7:0]};
                msie_pkg::PK_LH:  wval = {{16{ld_reg[15]}}, ld_reg[15:0]};
                msie_pkg::PK_LHU: wval = {16'd0, ld_reg[15:0]};
                default:          wval = ld_reg;
            endcase
        end
        else
        begin
            case (opc)
                msie_pkg::OP_SPECIAL:
                begin
                    case (fn)
                        msie_pkg::FN_SLL:
                        begin
                            wen = 1'b1; wval = b_reg << sh;
                        end
                        msie_pkg::FN_SRL:
                        begin
                            wen = 1'b1; wval = b_reg >> sh;
                        end
                        msie_pkg::FN_SRA:
                        begin
                            wen = 1'b1; wval = sra_v;
                        end
                        msie_pkg::FN_SLLV:
                        begin
                            wen = 1'b1; wval = b_reg << a_reg[4:0];
                        end
                        msie_pkg::FN_SRLV:
                        begin
                            wen = 1'b1; wval = b_reg >> a_reg[4:0];
                        end
                        msie_pkg::FN_JR:   npc = a_reg;
                        msie_pkg::FN_JALR:
                        begin
                            wen = 1'b1; wval = pc4; npc = a_reg;
                        end
                        msie_pkg::FN_SYSC: sflag = 1'b1;
                        msie_pkg::FN_MFHI:
                        begin
                            wen = 1'b1; wval = hi_reg;
                        end
                        msie_pkg::FN_MTHI: hi_wen = 1'b1;
                        msie_pkg::FN_MFLO:
                        begin
                            wen = 1'b1; wval = lo_reg;
                        end
                        msie_pkg::FN_MTLO: lo_wen = 1'b1;
                        msie_pkg::FN_ADD, msie_pkg::FN_ADDU:
                        begin
                            wen = 1'b1; wval = a_reg + b_reg;
                        end
                        msie_pkg::FN_SUB, msie_pkg::FN_SUBU:
                        begin
                            wen = 1'b1; wval = a_reg - b_reg;
                        end
                        msie_pkg::FN_AND:
                        begin
                            wen = 1'b1; wval = a_reg & b_reg;
                        end
                        msie_pkg::FN_OR:
                        begin
                            wen = 1'b1; wval = a_reg | b_reg;
                        end
                        msie_pkg::FN_XOR:
                        begin
                            wen = 1'b1; wval = a_reg ^ b_reg;
                        end
                        msie_pkg::FN_NOR:
                        begin
                            wen = 1'b1; wval = ~(a_reg | b_reg);
                        end
                        msie_pkg::FN_SLT:
                        begin
                            wen = 1'b1; wval = {31'd0, $signed(a_reg) < $signed(b_reg)};
                        end
                        msie_pkg::FN_SLTU:
                        begin
                            wen = 1'b1; wval = {31'd0, a_reg < b_reg};
                        end
                        default: wen = 1'b0;
                    endcase
                end
                msie_pkg::OP_JAL:
                begin
                    wen = 1'b1; wdst = RW'(31); wval = pc4;
                    npc = {pc_reg[31:28], w_reg[25:0], 2'b00};
                end
                msie_pkg::OP_J:    npc = {pc_reg[31:28], w_reg[25:0], 2'b00};
                msie_pkg::OP_BEQ:  if (a_reg == b_reg) npc = br;
                msie_pkg::OP_BNE:  if (a_reg != b_reg) npc = br;
                msie_pkg::OP_BLEZ: if (a_reg == 32'd0 || a_reg[31]) npc = br;
                msie_pkg::OP_BGTZ: if (a_reg != 32'd0 && !a_reg[31]) npc = br;
                msie_pkg::OP_ADDI, msie_pkg::OP_ADDIU:
                begin
                    wen = 1'b1; wdst = rt[RW-1:0]; wval = a_reg + simm;
                end
                msie_pkg::OP_SLTI:
                begin
                    wen = 1'b1; wdst = rt[RW-1:0];
                    wval = {31'd0, $signed(a_reg) < $signed(simm)};
                end
                msie_pkg::OP_SLTIU:
                begin
                    wen = 1'b1; wdst = rt[RW-1:0]; wval = {31'd0, a_reg < simm};
                end
                msie_pkg::OP_ANDI:
                begin
                    wen = 1'b1; wdst = rt[RW-1:0]; wval = a_reg & imm;
                end
                msie_pkg::OP_ORI:
                begin
                    wen = 1'b1; wdst = rt[RW-1:0]; wval = a_reg | imm;
                end
                msie_pkg::OP_XORI:
                begin
                    wen = 1'b1; wdst = rt[RW-1:0]; wval = a_reg ^ imm;
                end
                msie_pkg::OP_LB, msie_pkg::OP_LH, msie_pkg::OP_LW,
                msie_pkg::OP_LBU, msie_pkg::OP_LHU:
                begin
                    mop = msie_pkg::MEM_LOAD; maddr = ea; new_load = 1'b1;
                    case (opc)
                        msie_pkg::OP_LB:
                        begin
                            msize = 2'd0; nkind = msie_pkg::PK_LB;
                        end
                        msie_pkg::OP_LBU:
                        begin
                            msize = 2'd0; nkind = msie_pkg::PK_LBU;
                        end
                        msie_pkg::OP_LH:
                        begin
                            msize = 2'd1; nkind = msie_pkg::PK_LH;
                        end
                        msie_pkg::OP_LHU:
                        begin
                            msize = 2'd1; nkind = msie_pkg::PK_LHU;
                        end
                        default:
                        begin
                            msize = 2'd2; nkind = msie_pkg::PK_LW;
                        end
                    endcase
                end
                msie_pkg::OP_SB:
                begin
                    mop = msie_pkg::MEM_STORE; maddr = ea; msize = 2'd0;
                    sval = {24'd0, b_reg[7:0]};
                end
                msie_pkg::OP_SH:
                begin
                    mop = msie_pkg::MEM_STORE; maddr = ea; msize = 2'd1;
                    sval = {16'd0, b_reg[15:0]};
                end
                msie_pkg::OP_SW:
                begin
                    mop = msie_pkg::MEM_STORE; maddr = ea; msize = 2'd2; sval = b_reg;
                end
                default: wen = 1'b0;
            endcase
        end
    end

    // register file; sp/fp follow configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++)
            begin
                gpr_reg[i] <= (i == 29 || i == 30) ? msie_pkg::STACK_TOP_RESET : 32'd0;
            end
        end
        else if (cfg_fire)
        begin
            gpr_reg[29] <= cfg_data;
            gpr_reg[30] <= cfg_data;
        end
        else if (ctrl.exec && wen && wdst != '0)
        begin
            gpr_reg[wdst] <= wval;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg    <= '0;
            hi_reg    <= '0;
            lo_reg    <= '0;
            pdest_reg <= '0;
            pkind_reg <= msie_pkg::PK_NONE;
            dcnt_reg  <= '0;
        end
        else
        begin
            if (ctrl.exec)
            begin
                pc_reg <= npc;
                if (hi_wen) hi_reg <= a_reg;
                if (lo_wen) lo_reg <= a_reg;
                if (kind_reg)
                begin
                    pkind_reg <= msie_pkg::PK_NONE;
                    pdest_reg <= '0;
                end
                else if (new_load)
                begin
                    pkind_reg <= nkind;
                    pdest_reg <= rt[RW-1:0];
                end
            end
            if (ctrl.mul_step)
            begin
                {hi_reg, lo_reg} <= prod_reg + {ma_reg, 16'd0};
            end
            if (ctrl.div_start)
            begin
                dcnt_reg <= 6'd32;
            end
            else if (ctrl.div_step && dcnt_reg != 6'd0)
            begin
                dcnt_reg <= dcnt_reg - 6'd1;
            end
            if (ctrl.div_fix)
            begin
                if (dzero_reg)
                begin
                    lo_reg <= 32'hFFFF_FFFF;
                    hi_reg <= dnum_reg;
                end
                else
                begin
                    lo_reg <= dneg_q_reg ? -dq_reg : dq_reg;
                    hi_reg <= dneg_r_reg ? -dr_reg : dr_reg;
                end
            end
        end
    end

    // operand capture and multiply/divide working registers
    logic [32:0] sa_ext, sb_ext;
    logic        mul_signed, div_signed;
    logic [32:0] rem_sh;
    logic signed [49:0] plo, phi;
    assign mul_signed = fn == msie_pkg::FN_MULT;
    assign div_signed = fn == msie_pkg::FN_DIV;
    assign sa_ext = {mul_signed & a_reg[31], a_reg};
    assign sb_ext = {mul_signed & b_reg[31], b_reg};
    assign rem_sh = {dr_reg, dq_reg[31]};
    assign plo    = $signed(sa_ext) * $signed({1'b0, sb_ext[15:0]});
    assign phi    = $signed(sa_ext) * $signed(sb_ext[32:16]);

    always_ff @(posedge clk)
    begin
        if (ctrl.load_in)
        begin
            kind_reg <= kind;
            w_reg    <= instr_word;
            ld_reg   <= load_data;
            a_reg    <= instr_word[25:21] == 5'd0 ? 32'd0 : gpr_reg[instr_word[25:21]];
            b_reg    <= instr_word[20:16] == 5'd0 ? 32'd0 : gpr_reg[instr_word[20:16]];
            v0_reg   <= gpr_reg[2];
        end
        if (ctrl.mul_start)
        begin
            prod_reg <= {{14{plo[49]}}, plo};
            ma_reg   <= phi[47:0];
        end
        if (ctrl.div_start)
        begin
            dzero_reg  <= b_reg == 32'd0;
            dnum_reg   <= a_reg;
            dneg_q_reg <= div_signed && (a_reg[31] ^ b_reg[31]);
            dneg_r_reg <= div_signed && a_reg[31];
            dq_reg     <= (div_signed && a_reg[31]) ? -a_reg : a_reg;
            dd_reg     <= (div_signed && b_reg[31]) ? -b_reg : b_reg;
            dr_reg     <= '0;
        end
        else if (ctrl.div_step && dcnt_reg != 6'd0)
        begin
            if (rem_sh >= {1'b0, dd_reg})
            begin
                dr_reg <= 32'(rem_sh - {1'b0, dd_reg});
                dq_reg <= {dq_reg[30:0], 1'b1};
            end
            else
            begin
                dr_reg <= rem_sh[31:0];
                dq_reg <= {dq_reg[30:0], 1'b0};
            end
        end
        if (ctrl.exec)
        begin
            npc_reg   <= npc;
            mop_reg   <= mop;
            addr_reg  <= maddr;
            msize_reg <= msize;
            sval_reg  <= sval;
            sflag_reg <= sflag;
            scode_reg <= sflag ? v0_reg : 32'd0;
        end
    end

    assign next_pc      = npc_reg;
    assign mem_op       = mop_reg;
    assign mem_addr     = addr_reg;
    assign mem_size     = msize_reg;
    assign store_value  = sval_reg;
    assign syscall_flag = sflag_reg;
    assign syscall_code = scode_reg;

`ifndef SYNTHESIS
    a_r0_zero: assert property (@(posedge clk) disable iff (!rst_n)
        gpr_reg[0] == 32'd0)
        else $error("r0 written");
    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.div_start |=> dcnt_reg == 6'd32)
        else $error("divider count not loaded");
    a_pend_clr: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.exec && kind_reg) |=> pkind_reg == msie_pkg::PK_NONE)
        else $error("pending load not cleared");
`endif

endmodule

/* src/mips_subset_instruction_executor.sv */
// ============================================================================
// mips_subset_instruction_executor
// MIPS I integer subset executor; one instruction or load-data item at a time.
// ============================================================================
// Items pass through the EXEC and OUT states; MULT/MULTU add the MUL state
// (two partial-product passes), DIV/DIVU the DIV and DFIX states (radix-2
// divider). The controller handles one item at a time and takes no new item
// until its result is taken. Reset (rst_n, async low) clears PC, HI, LO, the
// pending load and the register file; sp and fp get the stack_top reset value.
module mips_subset_instruction_executor #(
    parameter int REG_COUNT = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // instr_word[31:0], load_data[63:32]
    input  logic        s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [135:0] m_tdata,  // next_pc, mem_op, mem_addr, mem_size,
                                   // store_value, syscall_flag, syscall_code, pad
    output logic        m_tuser    // unused flag slot: always zero
);

    msie_pkg::ctrl_t ctrl;
    msie_pkg::stat_t stat;
    logic in_fire, out_fire;
    logic [31:0] next_pc, mem_addr, store_value, syscall_code;
    logic [1:0]  mem_op, mem_size;
    logic        syscall_flag;

    assign cfg_ready = 1'b1;
    assign in_fire   = s_tvalid && s_tready;
    assign out_fire  = m_tvalid && m_tready;
    assign m_tuser   = 1'b0;
    assign m_tdata   = {3'd0, syscall_code, syscall_flag, store_value, mem_size,
                        mem_addr, mem_op, next_pc};

    msie_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .out_fire  (out_fire),
        .stat      (stat),
        .ctrl      (ctrl),
        .in_ready  (s_tready),
        .out_valid (m_tvalid)
    );

    msie_dp #(.REG_COUNT(REG_COUNT)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .stat         (stat),
        .cfg_fire     (cfg_valid),
        .cfg_data     (cfg_data),
        .kind         (s_tuser),
        .instr_word   (s_tdata[31:0]),
        .load_data    (s_tdata[63:32]),
        .next_pc      (next_pc),
        .mem_op       (mem_op),
        .mem_addr     (mem_addr),
        .mem_size     (mem_size),
        .store_value  (store_value),
        .syscall_flag (syscall_flag),
        .syscall_code (syscall_code)
    );

endmodule

/* tb/tb_mips_subset_instruction_executor.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb_mips_subset_instruction_executor
// Self-checking testbench: a directed program with known results, then random
// instruction streams checked against a cycle-free predictor of the executor.
// ============================================================================
module tb_mips_subset_instruction_executor;

    localparam logic [5:0] FN_BREAK = 6'd13;
    localparam int         WDOG_LIMIT = 3000;
    localparam int         PHASE_ITEMS = 100;

    typedef struct packed {
        logic [31:0] next_pc;
        logic [1:0]  mem_op;
        logic [31:0] mem_addr;
        logic [1:0]  mem_size;
        logic [31:0] store_value;
        logic        sc_flag;
        logic [31:0] sc_code;
    } exec_res_t;

    typedef struct {
        logic        kind;
        logic [31:0] word;
        logic [31:0] data;
        logic        typed;
        exec_res_t   res;
    } dir_row_t;

    logic         clk;
    logic         rst_n;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [31:0]  cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [63:0]  s_tdata;   // instr_word[31:0], load_data[63:32]
    logic         s_tuser;   // kind
    logic         m_tvalid;
    logic         m_tready;
    logic [135:0] m_tdata;   // next_pc, mem_op, mem_addr, mem_size, store_value,
                             // syscall_flag, syscall_code, pad
    logic         m_tuser;   // unused

    // predictor state
    logic [31:0]  gpr [32];
    logic [31:0]  pc_q, hi_q, lo_q, stack_q;
    logic [4:0]   pend_dest;
    msie_pkg::pend_kind_t pend_kind;

    exec_res_t    expected_q[$];
    dir_row_t     dir_rows[$];
    logic         typed_now;
    exec_res_t    typed_res;
    int           err_count;
    int           idle_cycles;
    logic         activity;
    logic         hold_req;
    logic         gen_pend;

    mips_subset_instruction_executor i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic [31:0] enc_r(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
                                          logic [4:0] rd, logic [4:0] sh);
        return {msie_pkg::OP_SPECIAL, rs, rt, rd, sh, fn};
    endfunction

    function automatic logic [31:0] enc_i(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                          logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    function automatic logic [31:0] sx16(logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] rd_gpr(logic [4:0] i);
        return (i == 5'd0) ? 32'd0 : gpr[i];
    endfunction

    task automatic wr_gpr(logic [4:0] i, logic [31:0] v);
        if (i != 5'd0)
            gpr[i] = v;
    endtask

    task automatic reset_model();
        for (int i = 0; i < 32; i++)
            gpr[i] = 32'd0;
        stack_q   = msie_pkg::STACK_TOP_RESET;
        gpr[29]   = stack_q;
        gpr[30]   = stack_q;
        pc_q      = 32'd0;
        hi_q      = 32'd0;
        lo_q      = 32'd0;
        pend_dest = 5'd0;
        pend_kind = msie_pkg::PK_NONE;
    endtask

    task automatic set_stack_top(logic [31:0] v);
        stack_q = v;
        gpr[29] = v;
        gpr[30] = v;
    endtask

    // advance the executor model by one item and return its result
    task automatic execute_item(input logic kind, input logic [31:0] w,
                                input logic [31:0] d, output exec_res_t r);
        logic [5:0]  opc, fn;
        logic [4:0]  rs, rt, rd, sh;
        logic [31:0] a, b, simm, br, ea, ua, ub, q, rm;
        logic [63:0] p;
        r = '0;
        r.next_pc = pc_q + 32'd4;
        if (kind)
        begin
            r.next_pc = pc_q;
            case (pend_kind)
                msie_pkg::PK_LB:  wr_gpr(pend_dest, {{24{d[7]}}, d[7:0]});
                msie_pkg::PK_LBU: wr_gpr(pend_dest, {24'd0, d[7:0]});
                msie_pkg::PK_LH:  wr_gpr(pend_dest, sx16(d[15:0]));
                msie_pkg::PK_LHU: wr_gpr(pend_dest, {16'd0, d[15:0]});
                msie_pkg::PK_LW:  wr_gpr(pend_dest, d);
                default: ;
            endcase
            pend_kind = msie_pkg::PK_NONE;
            pend_dest = 5'd0;
        end
        else
        begin
            opc  = w[31:26];
            rs   = w[25:21];
            rt   = w[20:16];
            rd   = w[15:11];
            sh   = w[10:6];
            fn   = w[5:0];
            a    = rd_gpr(rs);
            b    = rd_gpr(rt);
            simm = sx16(w[15:0]);
            br   = pc_q + (simm << 2);
            ea   = a + simm;
            case (opc)
                msie_pkg::OP_SPECIAL:
                begin
                    case (fn)
                        msie_pkg::FN_SLL:  wr_gpr(rd, b << sh);
                        msie_pkg::FN_SRL:  wr_gpr(rd, b >> sh);
                        msie_pkg::FN_SRA:  wr_gpr(rd, $signed(b) >>> sh);
                        msie_pkg::FN_SLLV: wr_gpr(rd, b << a[4:0]);
                        msie_pkg::FN_SRLV: wr_gpr(rd, b >> a[4:0]);
                        msie_pkg::FN_JR:   r.next_pc = a;
                        msie_pkg::FN_JALR:
                        begin
                            wr_gpr(rd, pc_q + 32'd4);
                            r.next_pc = a;
                        end
                        msie_pkg::FN_SYSC:
                        begin
                            r.sc_flag = 1'b1;
                            r.sc_code = rd_gpr(5'd2);
                        end
                        msie_pkg::FN_MFHI: wr_gpr(rd, hi_q);
                        msie_pkg::FN_MTHI: hi_q = a;
                        msie_pkg::FN_MFLO: wr_gpr(rd, lo_q);
                        msie_pkg::FN_MTLO: lo_q = a;
                        msie_pkg::FN_MULT:
                        begin
                            p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
                            lo_q = p[31:0];
                            hi_q = p[63:32];
                        end
                        msie_pkg::FN_MULTU:
                        begin
                            p = {32'd0, a} * {32'd0, b};
                            lo_q = p[31:0];
                            hi_q = p[63:32];
                        end
                        msie_pkg::FN_DIV:
                        begin
                            if (b == 32'd0)
                            begin
                                lo_q = 32'hFFFF_FFFF;
                                hi_q = a;
                            end
                            else
                            begin
                                ua = a[31] ? -a : a;
                                ub = b[31] ? -b : b;
                                q  = ua / ub;
                                rm = ua % ub;
                                lo_q = (a[31] ^ b[31]) ? -q : q;
                                hi_q = a[31] ? -rm : rm;
                            end
                        end
                        msie_pkg::FN_DIVU:
                        begin
                            if (b == 32'd0)
                            begin
                                lo_q = 32'hFFFF_FFFF;
                                hi_q = a;
                            end
                            else
                            begin
                                lo_q = a / b;
                                hi_q = a % b;
                            end
                        end
                        msie_pkg::FN_ADD, msie_pkg::FN_ADDU: wr_gpr(rd, a + b);
                        msie_pkg::FN_SUB, msie_pkg::FN_SUBU: wr_gpr(rd, a - b);
                        msie_pkg::FN_AND:  wr_gpr(rd, a & b);
                        msie_pkg::FN_OR:   wr_gpr(rd, a | b);
                        msie_pkg::FN_XOR:  wr_gpr(rd, a ^ b);
                        msie_pkg::FN_NOR:  wr_gpr(rd, ~(a | b));
                        msie_pkg::FN_SLT:  wr_gpr(rd, {31'd0, $signed(a) < $signed(b)});
                        msie_pkg::FN_SLTU: wr_gpr(rd, {31'd0, a < b});
                        default: ;
                    endcase
                end
                msie_pkg::OP_JAL:
                begin
                    wr_gpr(5'd31, pc_q + 32'd4);
                    r.next_pc = {pc_q[31:28], w[25:0], 2'b00};
                end
                msie_pkg::OP_J:    r.next_pc = {pc_q[31:28], w[25:0], 2'b00};
                msie_pkg::OP_BEQ:  if (a == b) r.next_pc = br;
                msie_pkg::OP_BNE:  if (a != b) r.next_pc = br;
                msie_pkg::OP_BLEZ: if ($signed(a) <= 0) r.next_pc = br;
                msie_pkg::OP_BGTZ: if ($signed(a) > 0) r.next_pc = br;
                msie_pkg::OP_ADDI, msie_pkg::OP_ADDIU: wr_gpr(rt, a + simm);
                msie_pkg::OP_SLTI:  wr_gpr(rt, {31'd0, $signed(a) < $signed(simm)});
                msie_pkg::OP_SLTIU: wr_gpr(rt, {31'd0, a < simm});
                msie_pkg::OP_ANDI:  wr_gpr(rt, a & {16'd0, w[15:0]});
                msie_pkg::OP_ORI:   wr_gpr(rt, a | {16'd0, w[15:0]});
                msie_pkg::OP_XORI:  wr_gpr(rt, a ^ {16'd0, w[15:0]});
                msie_pkg::OP_LB, msie_pkg::OP_LH, msie_pkg::OP_LW,
                msie_pkg::OP_LBU, msie_pkg::OP_LHU:
                begin
                    r.mem_op   = msie_pkg::MEM_LOAD;
                    r.mem_addr = ea;
                    pend_dest  = rt;
                    case (opc)
                        msie_pkg::OP_LB:
                        begin
                            r.mem_size = 2'd0; pend_kind = msie_pkg::PK_LB;
                        end
                        msie_pkg::OP_LBU:
                        begin
                            r.mem_size = 2'd0; pend_kind = msie_pkg::PK_LBU;
                        end
                        msie_pkg::OP_LH:
                        begin
                            r.mem_size = 2'd1; pend_kind = msie_pkg::PK_LH;
                        end
                        msie_pkg::OP_LHU:
                        begin
                            r.mem_size = 2'd1; pend_kind = msie_pkg::PK_LHU;
                        end
                        default:
                        begin
                            r.mem_size = 2'd2; pend_kind = msie_pkg::PK_LW;
                        end
                    endcase
                end
                msie_pkg::OP_SB:
                begin
                    r.mem_op = msie_pkg::MEM_STORE; r.mem_addr = ea; r.mem_size = 2'd0;
                    r.store_value = {24'd0, b[7:0]};
                end
                msie_pkg::OP_SH:
                begin
                    r.mem_op = msie_pkg::MEM_STORE; r.mem_addr = ea; r.mem_size = 2'd1;
                    r.store_value = {16'd0, b[15:0]};
                end
                msie_pkg::OP_SW:
                begin
                    r.mem_op = msie_pkg::MEM_STORE; r.mem_addr = ea; r.mem_size = 2'd2;
                    r.store_value = b;
                end
                default: ;
            endcase
        end
        pc_q = r.next_pc;
    endtask

    task automatic report(string field, logic [31:0] got, logic [31:0] want);
        $display("%0t mismatch %s: got %h expected %h", $realtime, field, got, want);
        err_count++;
    endtask

    // all handshakes are sampled at the falling edge; the transfer completes
    // at the rising edge that follows
    always @(negedge clk)
    begin
        exec_res_t r;
        exec_res_t e;
        activity <= (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                    (cfg_valid && cfg_ready);
        if (rst_n && s_tvalid && s_tready)
        begin
            execute_item(s_tuser, s_tdata[31:0], s_tdata[63:32], r);
            expected_q.push_back(typed_now ? typed_res : r);
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_q.size() == 0)
            begin
                report("unexpected result", m_tdata[31:0], 32'd0);
            end
            else
            begin
                e = expected_q.pop_front();
                if (m_tdata[31:0] !== e.next_pc)
                    report("next_pc", m_tdata[31:0], e.next_pc);
                if (m_tdata[33:32] !== e.mem_op)
                    report("mem_op", m_tdata[33:32], e.mem_op);
                if (m_tdata[65:34] !== e.mem_addr)
                    report("mem_addr", m_tdata[65:34], e.mem_addr);
                if (m_tdata[67:66] !== e.mem_size)
                    report("mem_size", m_tdata[67:66], e.mem_size);
                if (m_tdata[99:68] !== e.store_value)
                    report("store_value", m_tdata[99:68], e.store_value);
                if (m_tdata[100] !== e.sc_flag)
                    report("syscall_flag", m_tdata[100], e.sc_flag);
                if (m_tdata[132:101] !== e.sc_code)
                    report("syscall_code", m_tdata[132:101], e.sc_code);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || activity)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result side: own stall pattern, plus one long hold-off on request
    initial
    begin
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                hold_req = 1'b0;
                repeat (300) @(posedge clk);
            end
            else if ($urandom_range(0, 9) < 3)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(0, 6)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(0, 15)) @(posedge clk);
            end
        end
    end

    // call just after a rising edge; returns just after the accepting edge
    task automatic send_item(logic kind, logic [31:0] w, logic [31:0] d, logic typed,
                             exec_res_t res);
        s_tvalid  <= 1'b1;
        s_tuser   <= kind;
        s_tdata   <= {d, w};
        typed_now <= typed;
        typed_res <= res;
        forever
        begin
            @(negedge clk);
            if (s_tready)
                break;
        end
        @(posedge clk);
    endtask

    task automatic idle_gap();
        if ($urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    task automatic write_stack_top(logic [31:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        forever
        begin
            @(negedge clk);
            if (cfg_ready)
                break;
        end
        @(posedge clk);
        cfg_valid <= 1'b0;
        set_stack_top(v);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    function automatic logic [4:0] pick_reg();
        return ($urandom_range(0, 1) != 0) ? 5'($urandom_range(0, 9)) : 5'($urandom);
    endfunction

    function automatic logic [15:0] pick_imm();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h7FFF;
            3: return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_word();
        logic [5:0] fns [26] = '{msie_pkg::FN_SLL, msie_pkg::FN_SRL, msie_pkg::FN_SRA,
                                 msie_pkg::FN_SLLV, msie_pkg::FN_SRLV, msie_pkg::FN_JR,
                                 msie_pkg::FN_JALR, msie_pkg::FN_SYSC, FN_BREAK,
                                 msie_pkg::FN_MFHI, msie_pkg::FN_MTHI, msie_pkg::FN_MFLO,
                                 msie_pkg::FN_MTLO, msie_pkg::FN_MULT, msie_pkg::FN_MULTU,
                                 msie_pkg::FN_DIV, msie_pkg::FN_DIVU, msie_pkg::FN_ADD,
                                 msie_pkg::FN_ADDU, msie_pkg::FN_SUB, msie_pkg::FN_SUBU,
                                 msie_pkg::FN_AND, msie_pkg::FN_OR, msie_pkg::FN_XOR,
                                 msie_pkg::FN_NOR, msie_pkg::FN_SLT};
        logic [5:0] ops [20] = '{msie_pkg::OP_J, msie_pkg::OP_JAL, msie_pkg::OP_BEQ,
                                 msie_pkg::OP_BNE, msie_pkg::OP_BLEZ, msie_pkg::OP_BGTZ,
                                 msie_pkg::OP_ADDI, msie_pkg::OP_ADDIU, msie_pkg::OP_SLTI,
                                 msie_pkg::OP_SLTIU, msie_pkg::OP_ANDI, msie_pkg::OP_ORI,
                                 msie_pkg::OP_XORI, msie_pkg::OP_LB, msie_pkg::OP_LH,
                                 msie_pkg::OP_LW, msie_pkg::OP_LBU, msie_pkg::OP_LHU,
                                 msie_pkg::OP_SB, msie_pkg::OP_SW};
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
                return enc_r(($urandom_range(0, 26) == 26) ? msie_pkg::FN_SLTU
                             : fns[$urandom_range(0, 25)],
                             pick_reg(), pick_reg(), pick_reg(), 5'($urandom));
            4, 5, 6, 7:
                return enc_i(ops[$urandom_range(0, 19)], pick_reg(), pick_reg(), pick_imm());
            8:
                return enc_i(msie_pkg::OP_SH, pick_reg(), pick_reg(), pick_imm());
            default:
                return $urandom;
        endcase
    endfunction

    task automatic fill_directed();
        dir_row_t  row;
        exec_res_t z;
        z = '0;
        row.kind = 1'b0; row.data = 32'd0;
        // SW sp,0(r0): stack pointer after reset
        row.word = enc_i(msie_pkg::OP_SW, 5'd0, 5'd29, 16'h0000); row.typed = 1'b1;
        row.res = '{32'd4, msie_pkg::MEM_STORE, 32'd0, 2'd2, msie_pkg::STACK_TOP_RESET,
                    1'b0, 32'd0};
        dir_rows.push_back(row);
        // ADDIU r1,r0,-1
        row.word = enc_i(msie_pkg::OP_ADDIU, 5'd0, 5'd1, 16'hFFFF);
        row.res = z; row.res.next_pc = 32'd8;
        dir_rows.push_back(row);
        // SB r1,0x7FFF(r0)
        row.word = enc_i(msie_pkg::OP_SB, 5'd0, 5'd1, 16'h7FFF);
        row.res = '{32'd12, msie_pkg::MEM_STORE, 32'h0000_7FFF, 2'd0, 32'hFF, 1'b0, 32'd0};
        dir_rows.push_back(row);
        // SH r1,-32768(r0)
        row.word = enc_i(msie_pkg::OP_SH, 5'd0, 5'd1, 16'h8000);
        row.res = '{32'd16, msie_pkg::MEM_STORE, 32'hFFFF_8000, 2'd1, 32'hFFFF, 1'b0, 32'd0};
        dir_rows.push_back(row);
        // ORI v0,r0,0xFFFF then SYSCALL
        row.word = enc_i(msie_pkg::OP_ORI, 5'd0, 5'd2, 16'hFFFF);
        row.res = z; row.res.next_pc = 32'd20;
        dir_rows.push_back(row);
        row.word = enc_r(msie_pkg::FN_SYSC, 5'd0, 5'd0, 5'd0, 5'd0);
        row.res = '{32'd24, msie_pkg::MEM_NONE, 32'd0, 2'd0, 32'd0, 1'b1, 32'h0000_FFFF};
        dir_rows.push_back(row);
        row.typed = 1'b0;
        row.res = z;
        // divide by zero, then move out of HI/LO
        row.word = enc_r(msie_pkg::FN_DIV, 5'd1, 5'd0, 5'd0, 5'd0);   dir_rows.push_back(row);
        row.word = enc_r(msie_pkg::FN_MFLO, 5'd0, 5'd0, 5'd4, 5'd0);  dir_rows.push_back(row);
        row.word = enc_r(msie_pkg::FN_MFHI, 5'd0, 5'd0, 5'd5, 5'd0);  dir_rows.push_back(row);
        row.word = enc_r(msie_pkg::FN_DIVU, 5'd2, 5'd0, 5'd0, 5'd0);  dir_rows.push_back(row);
        row.word = enc_r(msie_pkg::FN_MFHI, 5'd0, 5'd0, 5'd5, 5'd0);  dir_rows.push_back(row);
        // most negative divided by minus one
        row.word = enc_r(msie_pkg::FN_SLL, 5'd0, 5'd1, 5'd8, 5'd31);  dir_rows.push_back(row);
        row.word = enc_r(msie_pkg::FN_DIV, 5'd8, 5'd1, 5'd0, 5'd0);   dir_rows.push_back(row);
        row.word = enc_r(msie_pkg::FN_MFLO, 5'd0, 5'd0, 5'd6, 5'd0);  dir_rows.push_back(row);
        row.word = enc_i(msie_pkg::OP_SW, 5'd0, 5'd6, 16'h0004);      dir_rows.push_back(row);
        // overflow wraps, arithmetic shift, variable shift, SLTIU
        row.word = enc_r(msie_pkg::FN_ADD, 5'd8, 5'd8, 5'd9, 5'd0);   dir_rows.push_back(row);
        row.word = enc_r(msie_pkg::FN_SRA, 5'd0, 5'd8, 5'd10, 5'd31); dir_rows.push_back(row);
        row.word = enc_r(msie_pkg::FN_SLLV, 5'd1, 5'd2, 5'd11, 5'd0); dir_rows.push_back(row);
        row.word = enc_i(msie_pkg::OP_SLTIU, 5'd2, 5'd12, 16'hFFFF);  dir_rows.push_back(row);
        // wide multiplies into HI:LO
        row.word = enc_r(msie_pkg::FN_MULT, 5'd8, 5'd8, 5'd0, 5'd0);  dir_rows.push_back(row);
        row.word = enc_r(msie_pkg::FN_MFHI, 5'd0, 5'd0, 5'd14, 5'd0); dir_rows.push_back(row);
        row.word = enc_r(msie_pkg::FN_MULTU, 5'd1, 5'd1, 5'd0, 5'd0); dir_rows.push_back(row);
        row.word = enc_r(msie_pkg::FN_MFHI, 5'd0, 5'd0, 5'd15, 5'd0); dir_rows.push_back(row);
        // write to r0 discarded
        row.word = enc_i(msie_pkg::OP_ADDIU, 5'd0, 5'd0, 16'h1234);   dir_rows.push_back(row);
        row.word = enc_i(msie_pkg::OP_SW, 5'd0, 5'd0, 16'h0000);      dir_rows.push_back(row);
        // load with sign extension, stray load data, unknown opcode
        row.word = enc_i(msie_pkg::OP_LB, 5'd29, 5'd13, 16'hFFFC);    dir_rows.push_back(row);
        row.kind = 1'b1; row.data = 32'hFFFF_FF80;                    dir_rows.push_back(row);
        row.data = 32'h1234_5678;                                     dir_rows.push_back(row);
        row.kind = 1'b0; row.word = 32'hFC00_0000;                    dir_rows.push_back(row);
        row.word = enc_i(msie_pkg::OP_BLEZ, 5'd10, 5'd0, 16'h8000);   dir_rows.push_back(row);
    endtask

    initial
    begin
        logic [31:0] cfg_vals [4];
        logic        k;
        logic [31:0] w;
        exec_res_t   z;
        int          sent;
        z         = '0;
        err_count = 0;
        hold_req  = 1'b0;
        gen_pend  = 1'b0;
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = 32'd0;
        s_tvalid  = 1'b0;
        s_tdata   = 64'd0;
        s_tuser   = 1'b0;
        typed_now = 1'b0;
        typed_res = '0;
        reset_model();
        fill_directed();
        cfg_vals[0] = 32'd0;
        cfg_vals[1] = 32'hFFFF_FFFC;
        cfg_vals[2] = $urandom;
        cfg_vals[3] = 32'hFFFF_FFFF;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            send_item(dir_rows[i].kind, dir_rows[i].word, dir_rows[i].data,
                      dir_rows[i].typed, dir_rows[i].res);
            idle_gap();
        end
        // sender waits for every outstanding result
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            write_stack_top(cfg_vals[ph]);
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                repeat ($urandom_range(1, 20))
                begin
                    if (gen_pend && $urandom_range(0, 3) != 0)
                    begin
                        k = 1'b1;
                        gen_pend = 1'b0;
                    end
                    else if ($urandom_range(0, 30) == 0)
                    begin
                        k = 1'b1;
                        gen_pend = 1'b0;
                    end
                    else
                    begin
                        k = 1'b0;
                    end
                    w = pick_word();
                    if (!k && w[31:29] == 3'b100 && w[28:26] inside {3'd0, 3'd1, 3'd3,
                                                                     3'd4, 3'd5})
                        gen_pend = 1'b1;
                    if (ph == 0 && sent == 30)
                        hold_req = 1'b1;
                    send_item(k, w, $urandom, 1'b0, z);
                    sent++;
                end
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            drain();
        end

        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
